FILE: hw/rtl/mhi_pkg.sv
// Shared types and codes for the min-heap insert/delete unit.
package mhi_pkg;

	// operation codes carried on the kind field
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_MISS  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// phase of an operation token as it walks down the cell chain
	typedef enum logic [1:0] {
		PH_ACTIVE,  // insert still placing its carry, or delete still searching
		PH_SHIFT,   // delete found its key; cells pull their right neighbor left
		PH_DONE     // operation finished, token just drains to the end
	} phase_t;

	// control part of a token handed from cell to cell
	typedef struct packed {
		logic   vld;
		logic   del;
		logic   found;
		phase_t phase;
	} tok_ctl_t;

endpackage

FILE: hw/rtl/mhi_cell.sv
// One cell of the sorted key chain: holds one key and steps an operation token.
module mhi_cell import mhi_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// token from the left neighbor
	input  tok_ctl_t                    up_ctl,
	input  logic signed [KEY_WIDTH-1:0] up_key,
	// contents of the right neighbor, pulled in during a delete shift
	input  logic signed [KEY_WIDTH-1:0] nxt_key,
	input  logic                        nxt_occ,
	// own contents
	output logic signed [KEY_WIDTH-1:0] key,
	output logic                        occ,
	// token to the right neighbor
	output tok_ctl_t                    dn_ctl,
	output logic signed [KEY_WIDTH-1:0] dn_key
);

	logic signed [KEY_WIDTH-1:0] key_q;
	logic signed [KEY_WIDTH-1:0] carry_q;
	logic                        occ_q;
	tok_ctl_t                    ctl_q;

	logic signed [KEY_WIDTH-1:0] key_d;
	logic signed [KEY_WIDTH-1:0] carry_d;
	logic                        occ_d;
	tok_ctl_t                    ctl_d;

	// step the token through this cell; chain stays sorted ascending
	always_comb begin
		key_d   = key_q;
		occ_d   = occ_q;
		ctl_d   = up_ctl;
		carry_d = up_key;
		if (up_ctl.vld) begin
			unique case (up_ctl.phase)
				PH_ACTIVE: begin
					if (!up_ctl.del) begin
						// insert: first empty cell takes the carry, smaller carry swaps in
						if (!occ_q) begin
							occ_d       = 1'b1;
							key_d       = up_key;
							ctl_d.phase = PH_DONE;
						end else if (up_key < key_q) begin
							key_d   = up_key;
							carry_d = key_q;
						end
					end else begin
						// delete search: past the key or past the end means absent
						if (!occ_q || key_q > up_key) begin
							ctl_d.phase = PH_DONE;
						end else if (key_q == up_key) begin
							key_d       = nxt_key;
							occ_d       = nxt_occ;
							ctl_d.found = 1'b1;
							ctl_d.phase = nxt_occ ? PH_SHIFT : PH_DONE;
						end
					end
				end
				PH_SHIFT: begin
					key_d = nxt_key;
					occ_d = nxt_occ;
					if (!nxt_occ) begin
						ctl_d.phase = PH_DONE;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			ctl_q <= '0;
		end else begin
			occ_q <= occ_d;
			ctl_q <= ctl_d;
		end
	end

	// key payload
	always_ff @(posedge clk) begin
		key_q   <= key_d;
		carry_q <= carry_d;
	end

	assign key    = key_q;
	assign occ    = occ_q;
	assign dn_ctl = ctl_q;
	assign dn_key = carry_q;

endmodule

FILE: hw/rtl/min_heap_insert_delete_unit.sv
// Top level of the min-heap insert/delete unit: controller and cell chain.
//
// Priority queue of signed keys with up to HEAP_DEPTH entries.
// Input channel (in_valid / in_stall): a beat carries kind (0 insert,
// 1 delete the first entry equal to value) and value, taken as a signed
// KEY_WIDTH-bit key (low bits, sign-extended).
// Output channel (out_valid / out_stall): exactly one beat per input beat
// with min_value (current minimum, zero when empty), entry_count and status
// (0 ok, 1 insert into full queue, 2 key not found, 3 queue empty).
// Keys sit sorted in a chain of HEAP_DEPTH cells. An operation token walks
// the chain one cell per cycle, and a normal insert or delete is answered once
// the token leaves the last cell; a full insert or an empty delete skips the chain.
// The next input beat can be taken in the cycle after the result is loaded
// into the output register, so the unit works on one beat at a time and its
// beat rate is set by the chain length.
// The output register holds a result while out_stall is high; one more
// finished result waits inside and blocks new input until it moves into that register.
// Reset empties the queue; no clearing pass is needed.
module min_heap_insert_delete_unit import mhi_pkg::*; #(
	parameter int HEAP_DEPTH = 32,
	parameter int KEY_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] min_value,
	output logic [5:0]         entry_count,
	output logic [1:0]         status
);

	localparam int CW = $clog2(HEAP_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_SEND
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic [1:0]                  res_status_q;
	tok_ctl_t                    tok_ctl_q;
	logic signed [KEY_WIDTH-1:0] tok_key_q;
	logic                        out_valid_q;
	logic signed [31:0]          min_value_q;
	logic [5:0]                  entry_count_q;
	logic [1:0]                  status_q;

	// chain wiring; index HEAP_DEPTH is the empty slot past the last cell
	tok_ctl_t                    chain_ctl [HEAP_DEPTH+1];
	logic signed [KEY_WIDTH-1:0] chain_key [HEAP_DEPTH+1];
	logic signed [KEY_WIDTH-1:0] cell_key  [HEAP_DEPTH+1];
	logic                        cell_occ  [HEAP_DEPTH+1];

	logic signed [KEY_WIDTH-1:0] in_key;
	logic signed [63:0]          min_x;
	logic                        full;
	logic                        out_free;

	assign in_key   = KEY_WIDTH'(value);
	assign min_x    = 64'(cell_key[0]);
	assign full     = (count_q == CW'(HEAP_DEPTH));
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	assign chain_ctl[0]          = tok_ctl_q;
	assign chain_key[0]          = tok_key_q;
	assign cell_key[HEAP_DEPTH]  = '0;
	assign cell_occ[HEAP_DEPTH]  = 1'b0;

	for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_cell
		mhi_cell #(
			.KEY_WIDTH (KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_ctl  (chain_ctl[g]),
			.up_key  (chain_key[g]),
			.nxt_key (cell_key[g+1]),
			.nxt_occ (cell_occ[g+1]),
			.key     (cell_key[g]),
			.occ     (cell_occ[g]),
			.dn_ctl  (chain_ctl[g+1]),
			.dn_key  (chain_key[g+1])
		);
	end

	// controller: launch a token, wait for it to leave the chain, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			res_status_q  <= ST_OK;
			tok_ctl_q     <= '0;
			tok_key_q     <= '0;
			out_valid_q   <= 1'b0;
			min_value_q   <= '0;
			entry_count_q <= '0;
			status_q      <= ST_OK;
		end else begin
			// a sent beat clears the output register unless a new result replaces it
			if (out_valid_q && !out_stall && state_q != S_SEND) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind == KIND_INSERT && full) begin
							res_status_q <= ST_FULL;
							state_q      <= S_SEND;
						end else if (kind == KIND_DELETE && count_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_SEND;
						end else begin
							tok_ctl_q.vld   <= 1'b1;
							tok_ctl_q.del   <= (kind == KIND_DELETE);
							tok_ctl_q.found <= 1'b0;
							tok_ctl_q.phase <= PH_ACTIVE;
							tok_key_q       <= in_key;
							state_q         <= S_RUN;
						end
					end
				end
				S_RUN: begin
					// token enters the chain for one cycle only
					tok_ctl_q.vld <= 1'b0;
					// token leaving the last cell ends the operation
					if (chain_ctl[HEAP_DEPTH].vld) begin
						if (!chain_ctl[HEAP_DEPTH].del) begin
							count_q      <= count_q + 1'b1;
							res_status_q <= ST_OK;
						end else if (chain_ctl[HEAP_DEPTH].found) begin
							count_q      <= count_q - 1'b1;
							res_status_q <= ST_OK;
						end else begin
							res_status_q <= ST_MISS;
						end
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						min_value_q   <= (count_q != '0) ? min_x[31:0] : 32'sd0;
						entry_count_q <= 6'(count_q);
						status_q      <= res_status_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign min_value   = min_value_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

FILE: verif/min_heap_insert_delete_unit_checker.sv
// Result checker for the min-heap insert/delete unit: mirrors the heap and compares every beat.
module min_heap_insert_delete_unit_checker import mhi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] min_value,
	input  logic [5:0]         entry_count,
	input  logic [1:0]         status,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 full_hits,
	output int                 miss_hits,
	output int                 empty_hits
);

	localparam int DEPTH      = 32;
	localparam int PRINT_CAP  = 40;

	// one predicted output beat
	typedef struct packed {
		logic signed [31:0] min_key;
		logic [5:0]         count;
		logic [1:0]         code;
	} heap_result_t;

	// mirror of the heap array, in heap order
	logic signed [31:0] keys [DEPTH];
	int                 fill = 0;

	heap_result_t result_q[$];
	int           fails     = 0;
	int           checked_n = 0;
	int           full_n    = 0;
	int           miss_n    = 0;
	int           empty_n   = 0;

	task automatic report_mismatch(input string msg);
		fails++;
		if (fails <= PRINT_CAP)
			$display("%0t MISMATCH: %s", $time, msg);
	endtask

	function automatic void swap_keys(input int a, input int b);
		logic signed [31:0] t;
		t       = keys[a];
		keys[a] = keys[b];
		keys[b] = t;
	endfunction

	function automatic void sift_up(input int slot);
		int at, parent;
		bit moving;
		at     = slot;
		moving = 1'b1;
		while (moving && at > 0) begin
			parent = (at - 1) / 2;
			if (keys[at] < keys[parent]) begin
				swap_keys(at, parent);
				at = parent;
			end else begin
				moving = 1'b0;
			end
		end
	endfunction

	// smaller child wins, left child on a tie
	function automatic void sift_down(input int slot);
		int at, child;
		bit moving;
		at     = slot;
		moving = 1'b1;
		while (moving) begin
			child = 2 * at + 1;
			if (child >= fill) begin
				moving = 1'b0;
			end else begin
				if (child + 1 < fill && keys[child + 1] < keys[child])
					child++;
				if (keys[child] < keys[at]) begin
					swap_keys(child, at);
					at = child;
				end else begin
					moving = 1'b0;
				end
			end
		end
	endfunction

	// apply one input beat to the mirror and return the beat the unit must answer with
	function automatic heap_result_t heap_apply(input logic op, input logic signed [31:0] key);
		heap_result_t res;
		int slot;
		res.code = ST_OK;
		slot     = -1;
		if (op == KIND_INSERT) begin
			if (fill >= DEPTH) begin
				res.code = ST_FULL;
			end else begin
				keys[fill] = key;
				fill++;
				sift_up(fill - 1);
			end
		end else if (fill == 0) begin
			res.code = ST_EMPTY;
		end else begin
			// first match in array order
			for (int i = 0; i < fill; i++)
				if (slot < 0 && keys[i] == key)
					slot = i;
			if (slot < 0) begin
				res.code = ST_MISS;
			end else begin
				fill--;
				// last entry fills the hole unless the hole was the last slot
				if (slot < fill) begin
					keys[slot] = keys[fill];
					sift_up(slot);
					sift_down(slot);
				end
			end
		end
		res.min_key = (fill > 0) ? keys[0] : 32'sd0;
		res.count   = 6'(fill);
		return res;
	endfunction

	// watch both channels; output beats are matched before the new input beat is queued
	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			fill = 0;
			keys = '{default: '0};
			result_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("output beat with nothing pending (min %0d count %0d status %0d)",
						min_value, entry_count, status));
				end else begin
					want = result_q.pop_front();
					checked_n++;
					if (min_value !== want.min_key)
						report_mismatch($sformatf("min_value got %0d want %0d", min_value, want.min_key));
					if (entry_count !== want.count)
						report_mismatch($sformatf("entry_count got %0d want %0d", entry_count, want.count));
					if (status !== want.code)
						report_mismatch($sformatf("status got %0d want %0d", status, want.code));
					case (want.code)
						ST_FULL:  full_n++;
						ST_MISS:  miss_n++;
						ST_EMPTY: empty_n++;
						default:  ;
					endcase
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(heap_apply(kind, value));
		end
		mismatches <= fails;
		pending    <= result_q.size();
		checked    <= checked_n;
		full_hits  <= full_n;
		miss_hits  <= miss_n;
		empty_hits <= empty_n;
	end

endmodule

FILE: verif/min_heap_insert_delete_unit_tb.sv
// Testbench top for the min-heap insert/delete unit: clock, reset, beat traffic and verdict.
module min_heap_insert_delete_unit_tb;
	import mhi_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int DEPTH          = 32;
	localparam int RANDOM_BEATS   = 1500;
	localparam int ROUND_BEATS    = 60;
	localparam int IDLE_PCT       = 15;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 300;
	localparam int CALM_FROM      = 850;
	localparam int CALM_TO        = 1050;
	localparam int DRAIN_CYCLES   = 2 * DEPTH + 10;
	localparam int TIMEOUT_CYCLES = 1_000_000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] min_value;
	logic [5:0]         entry_count;
	logic [1:0]         status;

	int mismatches, pending, checked, full_hits, miss_hits, empty_hits;

	// stimulus-side view of the queue contents, used to aim deletes at live keys
	logic signed [31:0] held_keys[$];
	int                 sent      = 0;
	int                 directed  = 0;
	int                 peak_fill = 0;
	int                 delivered = 0;

	min_heap_insert_delete_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.min_value   (min_value),
		.entry_count (entry_count),
		.status      (status)
	);

	min_heap_insert_delete_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.min_value   (min_value),
		.entry_count (entry_count),
		.status      (status),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.full_hits   (full_hits),
		.miss_hits   (miss_hits),
		.empty_hits  (empty_hits)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Timeout: %0d beats sent, %0d results pending", sent, pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// offer one beat, with random idle cycles ahead of it, and return at the accepting edge
	task automatic send_beat(input logic op, input logic signed [31:0] key);
		int idx;
		while (!(sent >= CALM_FROM && sent < CALM_TO) && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		value    <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		// track contents for later delete targets
		if (op == KIND_INSERT) begin
			if (held_keys.size() < DEPTH)
				held_keys.push_back(key);
		end else begin
			idx = -1;
			foreach (held_keys[i])
				if (idx < 0 && held_keys[i] == key)
					idx = i;
			if (idx >= 0)
				held_keys.delete(idx);
		end
		if (held_keys.size() > peak_fill)
			peak_fill = held_keys.size();
	endtask

	// keys: a narrow band for ties and duplicates, full range, and the ends of the range
	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(3))
			0, 1:    return $signed($urandom_range(8)) - 32'sd4;
			2:       return $signed($urandom());
			default: return $urandom_range(1) ? 32'sh7fff_ffff - $signed($urandom_range(2))
			                                  : 32'sh8000_0000 + $signed($urandom_range(2));
		endcase
	endfunction

	// deletes mostly hit a live key; the rest are likely misses
	function automatic logic signed [31:0] pick_delete_key();
		if (held_keys.size() > 0 && $urandom_range(99) < 85)
			return held_keys[$urandom_range(held_keys.size() - 1)];
		return pick_key();
	endfunction

	// receiver: random stalls, one long hold-off, one stretch with none
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held      = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				delivered++;
			if (!held && delivered >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (delivered >= CALM_FROM && delivered < CALM_TO) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// main stimulus
	initial begin
		int ins_pct;
		in_valid <= 1'b0;
		kind     <= KIND_INSERT;
		value    <= '0;
		arst_n   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty delete, range ends, ties, misses, root and last-slot deletes
		send_beat(KIND_DELETE, 32'sd5);
		send_beat(KIND_INSERT, 32'sd0);
		send_beat(KIND_INSERT, 32'sh7fff_ffff);
		send_beat(KIND_INSERT, 32'sh8000_0000);
		send_beat(KIND_INSERT, -32'sd1);
		send_beat(KIND_INSERT, 32'sd1);
		send_beat(KIND_INSERT, 32'sd0);
		send_beat(KIND_DELETE, 32'sd7);
		send_beat(KIND_DELETE, 32'sh8000_0000);
		send_beat(KIND_DELETE, 32'sd0);
		send_beat(KIND_INSERT, 32'sh5555_5555);
		send_beat(KIND_INSERT, 32'shaaaa_aaaa);
		send_beat(KIND_DELETE, 32'shaaaa_aaaa);
		send_beat(KIND_DELETE, 32'sh7fff_ffff);
		send_beat(KIND_DELETE, 32'sd1);
		send_beat(KIND_DELETE, 32'sd0);
		send_beat(KIND_DELETE, 32'sh5555_5555);
		send_beat(KIND_DELETE, -32'sd1);
		send_beat(KIND_DELETE, -32'sd1);
		send_beat(KIND_DELETE, 32'sh8000_0000);
		directed = sent;

		// random rounds: grow to full, churn, then drain to empty
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			case ((n / ROUND_BEATS) % 3)
				0:       ins_pct = 85;
				1:       ins_pct = 50;
				default: ins_pct = 15;
			endcase
			if ($urandom_range(99) < ins_pct)
				send_beat(KIND_INSERT, pick_key());
			else
				send_beat(KIND_DELETE, pick_delete_key());
		end
		in_valid <= 1'b0;

		// let the last results drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d beats (%0d directed), peak fill %0d of %0d, one %0d-cycle output hold-off",
			sent, directed, peak_fill, DEPTH, HOLD_CYCLES);
		$display("Checked %0d results: %0d full inserts, %0d misses, %0d empty deletes, %0d mismatches",
			checked, full_hits, miss_hits, empty_hits, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
